@@ hdl/range_allocator_coalescing_assert.svh @@
// Assertion macros used by the allocator datapath.
`ifndef RANGE_ALLOCATOR_COALESCING_ASSERT_SVH
`define RANGE_ALLOCATOR_COALESCING_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define RAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range allocator check failed");

// Next-cycle implication, checked on clk outside reset.
`define RAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range allocator check failed");

`endif

@@ hdl/rac_pkg.sv @@
// ----------------------------------------------------------------------------
// rac_pkg
// Constants, codes and control structs of the range allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package rac_pkg;

  localparam int NUM_RANGES = 16;
  localparam int IDX_W      = $clog2(NUM_RANGES);
  localparam int CNT_W      = $clog2(NUM_RANGES + 1);
  // Page size; must be a power of two.
  localparam int PAGE_BYTES = 4096;
  localparam logic [32:0] PAGE_MASK = 33'(PAGE_BYTES - 1);

  localparam logic [1:0] KIND_FREE   = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_MAPPED = 2'd2;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_MAP   = 3'd3;
  localparam logic [2:0] OP_UNMAP = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_FIT    = 2'd2;
  localparam logic [1:0] ST_ZERO      = 2'd3;

  localparam logic [1:0] SCAN_BEST  = 2'd0;
  localparam logic [1:0] SCAN_ADDR  = 2'd1;
  localparam logic [1:0] SCAN_MERGE = 2'd2;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       scan_start;
    logic [1:0] scan_mode;
    logic       wr_split;
    logic       wr_hit;
    logic [1:0] wr_kind;
    logic       set_st;
    logic [1:0] st_code;
    logic       set_base;
    logic       push;
  } rac_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       req_zero;
    logic       addr_zero;
    logic       len_zero;
    logic       size_over;
    logic       scan_done;
    logic       hit;
    logic       split_need;
    logic       out_free;
  } rac_sts_t;

endpackage
`default_nettype wire

@@ hdl/rac_ifs.sv @@
// ----------------------------------------------------------------------------
// rac_ifs
// Request and response channels of the range allocator.
// ----------------------------------------------------------------------------
`default_nettype none
interface rac_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] req_size;
  logic [31:0] addr;
  modport source (output valid, op, req_size, addr, input ready);
  modport sink (input valid, op, req_size, addr, output ready);
endinterface

interface rac_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] range_base;
  modport source (output valid, status, range_base, input ready);
  modport sink (input valid, status, range_base, output ready);
endinterface
`default_nettype wire

@@ hdl/range_allocator_coalescing.sv @@
// ----------------------------------------------------------------------------
// range_allocator_coalescing
// Best-fit allocator of address ranges with merging of free neighbors.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req      in         op, req_size, addr
//  rsp      out        status, range_base
//  apb      in/out     segment_base (0x0), segment_length (0x4)
//
// One request at a time. Init, rejected and unknown requests finish in the
// decode state. A lookup or fit search makes one pipelined pass over the
// 16-entry table, one read per cycle, and ends there on a miss; on a hit,
// map, unmap and alloc write the hit entry, alloc with split writes the
// spare entry first, and free runs a merge pass before its write.
// The table has a single read port; a stalled response adds its stall
// before the next request is taken.
// Reset clears the used bits at once; no clearing pass.
// A result waits in the response register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module range_allocator_coalescing (
  input  wire logic  clk,
  input  wire logic  rst,
  rac_req_if.sink    req,
  rac_rsp_if.source  rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rac_pkg::*;

  logic [31:0] segment_base, segment_length;
  rac_cmd_t cmd;
  rac_sts_t sts;

  // Config registers: decode on the register word bit only.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? segment_length : segment_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_base <= '0;
      segment_length <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        segment_length <= pwdata;
      end else begin
        segment_base <= pwdata;
      end
    end
  end

  // Sequencer drives the datapath by command struct.
  rac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, scan pipeline and response register.
  rac_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (req.op),
    .in_req_size (req.req_size),
    .in_addr     (req.addr),
    .seg_base    (segment_base),
    .seg_length  (segment_length),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_base    (rsp.range_base)
  );
endmodule
`default_nettype wire

@@ hdl/rac_ctrl.sv @@
// ----------------------------------------------------------------------------
// rac_ctrl
// Sequencer: decode a request, run table scans, issue the table writes.
// ----------------------------------------------------------------------------
`default_nettype none
module rac_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rac_pkg::rac_sts_t sts,
  output rac_pkg::rac_cmd_t      cmd
);
  import rac_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_MERGE  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        cmd.set_st = 1'b1;
        unique case (sts.op) inside
          OP_INIT: begin
            if (sts.len_zero) begin
              cmd.st_code = ST_ZERO;
            end else begin
              cmd.init = 1'b1;
              cmd.st_code = ST_OK;
            end
          end
          OP_ALLOC: begin
            if (sts.req_zero) begin
              cmd.st_code = ST_ZERO;
            end else if (sts.size_over) begin
              cmd.st_code = ST_NO_FIT;
            end else begin
              cmd.set_st = 1'b0;
              cmd.scan_start = 1'b1;
              cmd.scan_mode = SCAN_BEST;
              state_next = S_SCAN;
            end
          end
          OP_FREE, OP_MAP, OP_UNMAP: begin
            if (sts.addr_zero) begin
              cmd.st_code = ST_ZERO;
            end else begin
              cmd.set_st = 1'b0;
              cmd.scan_start = 1'b1;
              cmd.scan_mode = SCAN_ADDR;
              state_next = S_SCAN;
            end
          end
          default: cmd.st_code = ST_NOT_FOUND;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.set_st = 1'b1;
          if (!sts.hit) begin
            cmd.st_code = (sts.op == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
            state_next = S_DONE;
          end else if (sts.op == OP_ALLOC) begin
            cmd.st_code = ST_OK;
            cmd.set_base = 1'b1;
            state_next = sts.split_need ? S_SPLIT : S_WRITE;
          end else if (sts.op == OP_FREE) begin
            cmd.st_code = ST_OK;
            cmd.scan_start = 1'b1;
            cmd.scan_mode = SCAN_MERGE;
            state_next = S_MERGE;
          end else begin
            cmd.st_code = ST_OK;
            state_next = S_WRITE;
          end
        end
      end
      S_SPLIT: begin
        cmd.wr_split = 1'b1;
        state_next = S_WRITE;
      end
      S_MERGE: begin
        if (sts.scan_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_hit = 1'b1;
        case (sts.op)
          OP_FREE: cmd.wr_kind = KIND_FREE;
          OP_MAP:  cmd.wr_kind = KIND_MAPPED;
          default: cmd.wr_kind = KIND_ALLOC;
        endcase
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/rac_dp.sv @@
// ----------------------------------------------------------------------------
// rac_dp
// Range table, scan pipeline, request registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_allocator_coalescing_assert.svh"
module rac_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        in_op,
  input  wire logic [31:0]       in_req_size,
  input  wire logic [31:0]       in_addr,
  input  wire logic [31:0]       seg_base,
  input  wire logic [31:0]       seg_length,
  input  wire rac_pkg::rac_cmd_t cmd,
  output rac_pkg::rac_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [31:0]            out_base
);
  import rac_pkg::*;

  // table storage; kind/base/length live in memory, used bits in flops
  logic [1:0]  mem_kind [NUM_RANGES];
  logic [31:0] mem_base [NUM_RANGES];
  logic [31:0] mem_len  [NUM_RANGES];
  logic [NUM_RANGES-1:0] used;

  logic [2:0]  op;
  logic [31:0] addr;
  logic [32:0] size;
  logic [1:0]  st;
  logic [31:0] rbase;

  logic [CNT_W-1:0] scan_cnt;
  logic             scan_run;
  logic [1:0]       scan_mode;
  logic             rd_v;
  logic [IDX_W-1:0] rd_idx;
  logic [1:0]       rd_kind;
  logic [31:0]      rd_base, rd_len;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_base, hit_len;

  logic             spare_ok;
  logic [IDX_W-1:0] spare_idx;
  logic             issue, scan_done, take;
  logic [32:0]      x_end, r_end;
  logic [1:0]       want_kind;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [1:0]       wr_kind;
  logic [31:0]      wr_base, wr_len;

  // first unused slot
  always_comb begin
    spare_ok = 1'b0;
    spare_idx = '0;
    for (int i = NUM_RANGES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        spare_ok = 1'b1;
        spare_idx = IDX_W'(i);
      end
    end
  end

  assign issue = scan_run && (scan_cnt != CNT_W'(NUM_RANGES));
  assign scan_done = scan_run && !issue && !rd_v;
  assign want_kind = (op == OP_UNMAP) ? KIND_MAPPED : KIND_ALLOC;
  assign x_end = {1'b0, rd_base} + {1'b0, rd_len};
  assign r_end = {1'b0, hit_base} + {1'b0, hit_len};

  always_comb begin
    take = 1'b0;
    if (rd_v && used[rd_idx]) begin
      case (scan_mode)
        SCAN_BEST: take = (rd_kind == KIND_FREE) && ({1'b0, rd_len} >= size)
                          && (!hit || rd_len < hit_len);
        SCAN_ADDR: take = (rd_kind == want_kind) && (rd_base == addr) && !hit;
        default:   take = (rd_idx != hit_idx) && (rd_kind == KIND_FREE)
                          && (x_end == {1'b0, hit_base} || r_end == {1'b0, rd_base});
      endcase
    end
  end

  // single write port shared by init, split and final write
  always_comb begin
    wr_en = cmd.init || cmd.wr_split || cmd.wr_hit;
    wr_addr = hit_idx;
    wr_kind = cmd.wr_kind;
    wr_base = hit_base;
    wr_len = hit_len;
    if (cmd.init) begin
      wr_addr = '0;
      wr_kind = KIND_FREE;
      wr_base = seg_base;
      wr_len = seg_length;
    end else if (cmd.wr_split) begin
      wr_addr = spare_idx;
      wr_kind = KIND_FREE;
      wr_base = hit_base + size[31:0];
      wr_len = hit_len - size[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_kind[wr_addr] <= wr_kind;
      mem_base[wr_addr] <= wr_base;
      mem_len[wr_addr] <= wr_len;
    end
    rd_kind <= mem_kind[scan_cnt[IDX_W-1:0]];
    rd_base <= mem_base[scan_cnt[IDX_W-1:0]];
    rd_len <= mem_len[scan_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      scan_run <= 1'b0;
      rd_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init) begin
        used <= NUM_RANGES'(1);
      end else if (cmd.wr_split) begin
        used[spare_idx] <= 1'b1;
      end else if (take && scan_mode == SCAN_MERGE) begin
        used[rd_idx] <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_run <= 1'b1;
      end else if (scan_done) begin
        scan_run <= 1'b0;
      end
      rd_v <= issue;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      addr <= in_addr;
      size <= ({1'b0, in_req_size} + PAGE_MASK) & ~PAGE_MASK;
      rbase <= '0;
    end
    if (cmd.scan_start) begin
      scan_cnt <= '0;
      scan_mode <= cmd.scan_mode;
    end else if (issue) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
    if (issue) begin
      rd_idx <= scan_cnt[IDX_W-1:0];
    end
    if (cmd.scan_start && cmd.scan_mode != SCAN_MERGE) begin
      hit <= 1'b0;
    end else if (take) begin
      hit <= 1'b1;
      if (scan_mode == SCAN_MERGE) begin
        // absorb the neighbor: below moves the base, above only grows
        if (x_end == {1'b0, hit_base}) begin
          hit_base <= rd_base;
        end
        hit_len <= hit_len + rd_len;
      end else begin
        hit_idx <= rd_idx;
        hit_base <= rd_base;
        hit_len <= rd_len;
      end
    end else if (cmd.wr_split) begin
      hit_len <= size[31:0];
    end
    if (cmd.set_st) begin
      st <= cmd.st_code;
    end
    if (cmd.set_base) begin
      rbase <= hit_base;
    end
    if (cmd.push) begin
      out_status <= st;
      out_base <= rbase;
    end
  end

  always_comb begin
    sts.op = op;
    sts.req_zero = (size == '0);
    sts.addr_zero = (addr == '0);
    sts.len_zero = (seg_length == '0);
    sts.size_over = size[32];
    sts.scan_done = scan_done;
    sts.hit = hit;
    sts.split_need = (hit_len > size[31:0]) && spare_ok;
    sts.out_free = !out_valid || out_ready;
  end

  `RAC_ASSERT_NEXT(a_init_slot0, cmd.init, used[0])
  `RAC_ASSERT_NOW(a_split_spare, cmd.wr_split, spare_ok && hit)
  `RAC_ASSERT_NOW(a_scan_end, scan_done, scan_cnt == CNT_W'(NUM_RANGES))
  `RAC_ASSERT_NOW(a_one_write, wr_en, !(cmd.init && (cmd.wr_split || cmd.wr_hit)))
endmodule
`default_nettype wire

@@ test/range_allocator_coalescing_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_allocator_coalescing_tb
// Self-checking bench for the range allocator: a behavioral table of ranges
// predicts status and base of every request; responses are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none
module range_allocator_coalescing_tb;
  import rac_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] range_base;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rac_req_if req ();
  rac_rsp_if rsp ();

  range_allocator_coalescing dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted copy of the range table and the segment registers.
  logic [31:0] seg_base_q, seg_len_q;
  logic        tbl_used [NUM_RANGES];
  logic [1:0]  tbl_kind [NUM_RANGES];
  logic [31:0] tbl_base [NUM_RANGES];
  logic [31:0] tbl_len  [NUM_RANGES];

  alloc_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_ok = 0;
  int n_checked = 0;
  int max_stall = 3;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
  endtask

  // Merge free range r with touching free neighbors in one slot-order pass.
  function automatic void coalesce(input int r);
    logic [32:0] x_end, r_end;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (i == r || !tbl_used[i] || tbl_kind[i] != KIND_FREE) continue;
      x_end = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
      r_end = {1'b0, tbl_base[r]} + {1'b0, tbl_len[r]};
      if (x_end == {1'b0, tbl_base[r]}) begin
        tbl_base[r] = tbl_base[i];
        tbl_len[r]  = tbl_len[r] + tbl_len[i];
        tbl_used[i] = 1'b0;
      end else if (r_end == {1'b0, tbl_base[i]}) begin
        tbl_len[r]  = tbl_len[r] + tbl_len[i];
        tbl_used[i] = 1'b0;
      end
    end
  endfunction

  function automatic alloc_result_t predict_request(input logic [2:0] op,
      input logic [31:0] size, input logic [31:0] addr);
    alloc_result_t res;
    logic [32:0] need;
    int best, hit, spare;
    logic [1:0] want_kind;
    res.status = ST_NOT_FOUND;
    res.range_base = '0;
    case (op)
      OP_INIT: begin
        if (seg_len_q == 0) res.status = ST_ZERO;
        else begin
          foreach (tbl_used[i]) tbl_used[i] = 1'b0;
          tbl_used[0] = 1'b1; tbl_kind[0] = KIND_FREE;
          tbl_base[0] = seg_base_q; tbl_len[0] = seg_len_q;
          res.status = ST_OK;
        end
      end
      OP_ALLOC: begin
        need = (({1'b0, size} + PAGE_MASK) & ~PAGE_MASK);
        best = -1;
        if (size == 0) res.status = ST_ZERO;
        else if (need[32]) res.status = ST_NO_FIT;
        else begin
          for (int i = 0; i < NUM_RANGES; i++)
            if (tbl_used[i] && tbl_kind[i] == KIND_FREE && {1'b0, tbl_len[i]} >= need
                && (best < 0 || tbl_len[i] < tbl_len[best])) best = i;
          if (best < 0) res.status = ST_NO_FIT;
          else begin
            if ({1'b0, tbl_len[best]} > need) begin
              spare = -1;
              for (int i = NUM_RANGES - 1; i >= 0; i--) if (!tbl_used[i]) spare = i;
              if (spare >= 0) begin
                tbl_used[spare] = 1'b1; tbl_kind[spare] = KIND_FREE;
                tbl_base[spare] = tbl_base[best] + need[31:0];
                tbl_len[spare]  = tbl_len[best] - need[31:0];
                tbl_len[best]   = need[31:0];
              end
            end
            tbl_kind[best] = KIND_ALLOC;
            res.status = ST_OK;
            res.range_base = tbl_base[best];
          end
        end
      end
      OP_FREE, OP_MAP, OP_UNMAP: begin
        want_kind = (op == OP_UNMAP) ? KIND_MAPPED : KIND_ALLOC;
        hit = -1;
        for (int i = NUM_RANGES - 1; i >= 0; i--)
          if (tbl_used[i] && tbl_kind[i] == want_kind && tbl_base[i] == addr) hit = i;
        if (addr == 0) res.status = ST_ZERO;
        else if (hit >= 0) begin
          res.status = ST_OK;
          if (op == OP_FREE) begin
            tbl_kind[hit] = KIND_FREE;
            coalesce(hit);
          end else tbl_kind[hit] = (op == OP_MAP) ? KIND_MAPPED : KIND_ALLOC;
        end
      end
      default: res.status = ST_NOT_FOUND;
    endcase
    return res;
  endfunction

  // Gap length: mostly short, occasionally long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Drive one request and record its expected response on the transfer.
  // Valid drops between requests.
  task automatic send_request(input logic [2:0] op, input logic [31:0] size,
      input logic [31:0] addr);
    int gap;
    gap = idle_gap();
    repeat (gap + 1) @(negedge clk);
    req.valid    <= 1'b1;
    req.op       <= op;
    req.req_size <= size;
    req.addr     <= addr;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_request(op, size, addr));
    n_sent++;
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // Responder: random stalls on ready.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 40) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(negedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(0, max_stall) == 0) ? 1'b0 : 1'b1;
      end
    end
  end

  // Compare on each response transfer.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected response status", 32'(rsp.status), '0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.status == ST_OK) n_ok++;
        if (rsp.status !== want.status)
          report("status", 32'(rsp.status), 32'(want.status));
        if (rsp.range_base !== want.range_base)
          report("range_base", rsp.range_base, want.range_base);
      end
    end
  end

  // Write a segment register between phases, when nothing is outstanding.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'h0) seg_base_q = data; else seg_len_q = data;
  endtask

  task automatic set_segment(input logic [31:0] base, input logic [31:0] len);
    write_reg(3'h0, base);
    write_reg(3'h4, len);
  endtask

  // Pick an address of an allocated or mapped range, or a random one.
  function automatic logic [31:0] pick_base(input logic [1:0] kind);
    int cand[$];
    for (int i = 0; i < NUM_RANGES; i++)
      if (tbl_used[i] && tbl_kind[i] == kind) cand.push_back(i);
    if (cand.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
    return tbl_base[cand[$urandom_range(0, cand.size() - 1)]];
  endfunction

  task automatic test_directed();
    set_segment(32'h0010_0000, 32'h0001_0000);
    send_request(OP_ALLOC, 32'h1000, 0);          // table empty: no fit
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 0, 0);                 // zero size
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 0);     // rounds past 32 bits
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 32'h1001, 0);
    send_request(OP_ALLOC, 32'h3000, 0);
    send_request(OP_MAP, 32'h0010_1000, 32'h0010_1000);
    send_request(OP_FREE, 0, 32'h0010_1000);      // mapped: not found
    send_request(OP_UNMAP, 0, 32'h0010_1000);
    send_request(OP_FREE, 0, 0);                  // zero address
    send_request(OP_MAP, 0, 0);
    send_request(OP_UNMAP, 0, 0);
    send_request(OP_FREE, 0, 32'h0010_1000);
    send_request(OP_FREE, 0, 32'h0010_0000);      // merges with neighbor
    send_request(OP_FREE, 0, 32'h0010_3000);      // merges everything
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd6, 0, 0);
    send_request(3'd7, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_request(OP_ALLOC, 32'h0001_0000, 0);     // exact fit
    send_request(OP_ALLOC, 32'h1000, 0);          // nothing left
    set_segment(32'h0, 32'h0);
    send_request(OP_INIT, 0, 0);                  // zero length
  endtask

  // Fragment the table past its slot count so the no-spare path is hit.
  task automatic test_full_table();
    set_segment(32'hFFFF_0000, 32'h0004_0000);    // wraps around zero
    send_request(OP_INIT, 0, 0);
    repeat (20) send_request(OP_ALLOC, $urandom_range(1, 32'h2000), 0);
    repeat (20) send_request(OP_FREE, 0, pick_base(KIND_ALLOC));
  endtask

  task automatic test_random(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_request(OP_INIT, $urandom(), $urandom());
      else if (r < 40) send_request(OP_ALLOC,
          ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 32'h6000), $urandom());
      else if (r < 70) send_request(OP_FREE, $urandom(), pick_base(KIND_ALLOC));
      else if (r < 82) send_request(OP_MAP, $urandom(), pick_base(KIND_ALLOC));
      else if (r < 94) send_request(OP_UNMAP, $urandom(), pick_base(KIND_MAPPED));
      else if (r < 97) send_request(3'($urandom_range(5, 7)), $urandom(), $urandom());
      else send_request(3'($urandom_range(2, 4)), $urandom(), 0);
    end
  endtask

  initial begin
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    seg_base_q = '0; seg_len_q = '0;
    req.valid = 1'b0; req.op = '0; req.req_size = '0; req.addr = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    // Walk through several segment settings, the extremes among them.
    set_segment(32'h4000_0000, 32'h0002_0000);
    test_random(400);
    set_segment(32'hFFFF_F000, 32'h0000_1000);
    send_request(OP_INIT, 0, 0);
    test_random(100);
    set_segment(32'h0000_1000, 32'hFFFF_F000);
    send_request(OP_INIT, 0, 0);
    max_stall = 1;
    test_random(400);
    max_stall = 3;
    set_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INIT, 0, 0);
    test_random(150);
    set_segment($urandom() & 32'hFFFF_F000, 32'h0008_0000);
    send_request(OP_INIT, 0, 0);
    test_random(250);

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses (%0d ok) over %0d cycles",
             n_sent, n_checked, n_ok, cycles);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d responses missing", errors, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
